// ----- sv/mie_pkg.sv -----
// ----------------------------------------------------------------------------
// MIPS-I integer execute package
// Shared result, exception, load, opcode and function codes for the integer execute unit.
// ----------------------------------------------------------------------------
package mie_pkg;

   localparam int REG_COUNT = 32;
   localparam int REG_AW    = $clog2(REG_COUNT);

   localparam logic [2:0] RK_DONE   = 3'd0;
   localparam logic [2:0] RK_BRANCH = 3'd1;
   localparam logic [2:0] RK_LOAD   = 3'd2;
   localparam logic [2:0] RK_STORE  = 3'd3;
   localparam logic [2:0] RK_EXC    = 3'd4;

   localparam logic [2:0] EX_ADEL = 3'd0;
   localparam logic [2:0] EX_ADES = 3'd1;
   localparam logic [2:0] EX_OVF  = 3'd2;
   localparam logic [2:0] EX_RI   = 3'd3;
   localparam logic [2:0] EX_CPU  = 3'd4;
   localparam logic [2:0] EX_SYS  = 3'd5;
   localparam logic [2:0] EX_BRK  = 3'd6;

   localparam logic [2:0] LT_LB  = 3'd0;
   localparam logic [2:0] LT_LBU = 3'd1;
   localparam logic [2:0] LT_LH  = 3'd2;
   localparam logic [2:0] LT_LHU = 3'd3;
   localparam logic [2:0] LT_LW  = 3'd4;
   localparam logic [2:0] LT_LWL = 3'd5;
   localparam logic [2:0] LT_LWR = 3'd6;

   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_REGIMM  = 6'h01;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_BLEZ    = 6'h06;
   localparam logic [5:0] OP_BGTZ    = 6'h07;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_SLTIU   = 6'h0B;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_XORI    = 6'h0E;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_COP0    = 6'h10;
   localparam logic [5:0] OP_COP1    = 6'h11;
   localparam logic [5:0] OP_COP2    = 6'h12;
   localparam logic [5:0] OP_COP3    = 6'h13;
   localparam logic [5:0] OP_LB      = 6'h20;
   localparam logic [5:0] OP_LH      = 6'h21;
   localparam logic [5:0] OP_LWL     = 6'h22;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_LBU     = 6'h24;
   localparam logic [5:0] OP_LHU     = 6'h25;
   localparam logic [5:0] OP_LWR     = 6'h26;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SWL     = 6'h2A;
   localparam logic [5:0] OP_SW      = 6'h2B;
   localparam logic [5:0] OP_SWR     = 6'h2E;
   localparam logic [5:0] OP_LWC0    = 6'h30;
   localparam logic [5:0] OP_LWC1    = 6'h31;
   localparam logic [5:0] OP_LWC2    = 6'h32;
   localparam logic [5:0] OP_LWC3    = 6'h33;
   localparam logic [5:0] OP_SWC0    = 6'h38;
   localparam logic [5:0] OP_SWC1    = 6'h39;
   localparam logic [5:0] OP_SWC2    = 6'h3A;
   localparam logic [5:0] OP_SWC3    = 6'h3B;

   localparam logic [5:0] FN_SLL     = 6'd0;
   localparam logic [5:0] FN_SRL     = 6'd2;
   localparam logic [5:0] FN_SRA     = 6'd3;
   localparam logic [5:0] FN_SLLV    = 6'd4;
   localparam logic [5:0] FN_SRLV    = 6'd6;
   localparam logic [5:0] FN_SRAV    = 6'd7;
   localparam logic [5:0] FN_JR      = 6'd8;
   localparam logic [5:0] FN_JALR    = 6'd9;
   localparam logic [5:0] FN_SYSCALL = 6'd12;
   localparam logic [5:0] FN_BREAK   = 6'd13;
   localparam logic [5:0] FN_MFHI    = 6'd16;
   localparam logic [5:0] FN_MTHI    = 6'd17;
   localparam logic [5:0] FN_MFLO    = 6'd18;
   localparam logic [5:0] FN_MTLO    = 6'd19;
   localparam logic [5:0] FN_MULT    = 6'd24;
   localparam logic [5:0] FN_MULTU   = 6'd25;
   localparam logic [5:0] FN_DIV     = 6'd26;
   localparam logic [5:0] FN_DIVU    = 6'd27;
   localparam logic [5:0] FN_ADD     = 6'd32;
   localparam logic [5:0] FN_ADDU    = 6'd33;
   localparam logic [5:0] FN_SUB     = 6'd34;
   localparam logic [5:0] FN_SUBU    = 6'd35;
   localparam logic [5:0] FN_AND     = 6'd36;
   localparam logic [5:0] FN_OR      = 6'd37;
   localparam logic [5:0] FN_XOR     = 6'd38;
   localparam logic [5:0] FN_NOR     = 6'd39;
   localparam logic [5:0] FN_SLT     = 6'd42;
   localparam logic [5:0] FN_SLTU    = 6'd43;

   localparam logic [4:0] RT_BLTZ   = 5'd0;
   localparam logic [4:0] RT_BGEZ   = 5'd1;
   localparam logic [4:0] RT_BLTZAL = 5'd16;
   localparam logic [4:0] RT_BGEZAL = 5'd17;

   localparam logic [4:0] LINK_REG = 5'd31;

endpackage

// ----- sv/mips1_integer_execute_unit.sv -----
// ----------------------------------------------------------------------------
// MIPS-I integer execute unit
// Executes one instruction word or one returning load word at a time. An
// item passes through accept, register file read, and execute and
// writeback; the execute step holds while a result waits. MULT/MULTU and
// DIV/DIVU with a nonzero divisor then run on a shared 33-bit add/subtract
// unit that makes one multiply or divide step per cycle, then a sign fix-up
// step. The result register frees the input side, so a new item is taken
// while a result waits. Register file is a 32-entry memory with registered
// reads and per-entry valid bits (entry 0 always reads zero).
// ----------------------------------------------------------------------------
module mips1_integer_execute_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [31:0] req_instruction,
   input  logic [31:0] req_instr_address,
   input  logic        req_in_delay_slot,
   input  logic [31:0] req_load_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_result_kind,
   output logic [31:0] rsp_mem_address,
   output logic [31:0] rsp_store_data,
   output logic [3:0]  rsp_byte_mask,
   output logic [31:0] rsp_next_pc,
   output logic [2:0]  rsp_exception_code,
   output logic [1:0]  rsp_cop_number,
   output logic        rsp_exc_in_slot
);

   typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_FIX} state_type;

   state_type state_ff;

   logic        kind_ff;
   logic [31:0] ins_ff, pc_ff, lw_ff;
   logic        slot_ff;

   logic [31:0] gpr_mem [mie_pkg::REG_COUNT];
   logic [mie_pkg::REG_COUNT-1:0] vld_ff;
   logic [31:0] rda_ff, rdb_ff;
   logic [mie_pkg::REG_AW-1:0] rdb_addr;

   logic [31:0] hi_ff, lo_ff;
   logic        ldp_ff;
   logic [4:0]  ldd_ff;
   logic [2:0]  ldt_ff;
   logic [1:0]  ldo_ff;

   logic [31:0] mh_ff, ml_ff, mc_ff;
   logic [4:0]  cnt_ff;
   logic        qneg_ff, rneg_ff, ismul_ff;

   logic        rsp_valid_ff;
   logic [2:0]  rk_ff, exc_ff;
   logic [31:0] addr_ff, sd_ff, npc_ff;
   logic [3:0]  mask_ff;
   logic [1:0]  cop_ff;
   logic        eslot_ff;

   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sa;
   logic [31:0] imm, simm, a, b, t, sum, dif, br_tgt, pc4, pc8, ldrt, ld_v, w_sh;
   logic [4:0]  sh, shc;
   logic        out_free, do_commit;

   logic [2:0]  ex_kind, ex_exc;
   logic [31:0] ex_addr, ex_sd, ex_npc;
   logic [3:0]  ex_mask;
   logic [1:0]  ex_cop;
   logic        ex_we;
   logic [4:0]  ex_wa;
   logic [31:0] ex_wd;
   logic        ex_hwe, ex_lwe;
   logic [31:0] ex_hd, ex_ld;
   logic        ex_mul, ex_div, ex_sgn;
   logic        ex_ldset;
   logic [2:0]  ex_ldt;

   logic        au_sub;
   logic [32:0] au_x, au_y;
   logic [33:0] au_sum;
   logic [63:0] prod_neg;

   logic        we;
   logic [4:0]  wa;
   logic [31:0] wd;

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rk_ff;
   assign rsp_mem_address    = addr_ff;
   assign rsp_store_data     = sd_ff;
   assign rsp_byte_mask      = mask_ff;
   assign rsp_next_pc        = npc_ff;
   assign rsp_exception_code = exc_ff;
   assign rsp_cop_number     = cop_ff;
   assign rsp_exc_in_slot    = eslot_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign do_commit = (state_ff == S_EXEC) && out_free;

   assign op   = ins_ff[31:26];
   assign rs   = ins_ff[25:21];
   assign rt   = ins_ff[20:16];
   assign rd   = ins_ff[15:11];
   assign sa   = ins_ff[10:6];
   assign fn   = ins_ff[5:0];
   assign imm  = {16'h0000, ins_ff[15:0]};
   assign simm = {{16{ins_ff[15]}}, ins_ff[15:0]};
   assign a    = vld_ff[rs] ? rda_ff : 32'h0;
   assign b    = vld_ff[rt] ? rdb_ff : 32'h0;
   assign ldrt = vld_ff[ldd_ff] ? rdb_ff : 32'h0;
   assign t    = a + simm;
   assign sum  = a + b;
   assign dif  = a - b;
   assign pc4  = pc_ff + 32'd4;
   assign pc8  = pc_ff + 32'd8;
   assign br_tgt = pc_ff + 32'd4 + {simm[29:0], 2'b00};
   assign sh   = {t[1:0], 3'b000};
   assign shc  = 5'd24 - sh;
   assign rdb_addr = kind_ff ? ldd_ff : rt;

   // load merge
   always_comb begin
      logic [4:0] lsh;
      lsh  = {ldo_ff, 3'b000};
      w_sh = lw_ff >> lsh;
      case (ldt_ff)
         mie_pkg::LT_LB:  ld_v = {{24{w_sh[7]}}, w_sh[7:0]};
         mie_pkg::LT_LBU: ld_v = {24'h0, w_sh[7:0]};
         mie_pkg::LT_LH:  ld_v = ldo_ff[1] ? {{16{lw_ff[31]}}, lw_ff[31:16]}
                                           : {{16{lw_ff[15]}}, lw_ff[15:0]};
         mie_pkg::LT_LHU: ld_v = ldo_ff[1] ? {16'h0, lw_ff[31:16]} : {16'h0, lw_ff[15:0]};
         mie_pkg::LT_LWL: ld_v = (lw_ff << (5'd24 - lsh)) | (ldrt & (32'h00FFFFFF >> lsh));
         mie_pkg::LT_LWR: ld_v = w_sh | (ldrt & ~(32'hFFFFFFFF >> lsh));
         default:         ld_v = lw_ff;
      endcase
   end

   // decode and execute
   always_comb begin
      ex_kind = mie_pkg::RK_DONE;
      ex_exc  = mie_pkg::EX_ADEL;
      ex_addr = '0;
      ex_sd   = '0;
      ex_npc  = '0;
      ex_mask = '0;
      ex_cop  = '0;
      ex_we   = 1'b0;
      ex_wa   = rd;
      ex_wd   = '0;
      ex_hwe  = 1'b0;
      ex_lwe  = 1'b0;
      ex_hd   = a;
      ex_ld   = a;
      ex_mul  = 1'b0;
      ex_div  = 1'b0;
      ex_sgn  = 1'b0;
      ex_ldset = 1'b0;
      ex_ldt  = mie_pkg::LT_LB;
      if (kind_ff) begin
         ex_we = ldp_ff;
         ex_wa = ldd_ff;
         ex_wd = ld_v;
      end else if (op == mie_pkg::OP_SPECIAL) begin
         ex_we = 1'b1;
         case (fn)
            mie_pkg::FN_SLL:  ex_wd = b << sa;
            mie_pkg::FN_SRL:  ex_wd = b >> sa;
            mie_pkg::FN_SRA:  ex_wd = $signed(b) >>> sa;
            mie_pkg::FN_SLLV: ex_wd = b << a[4:0];
            mie_pkg::FN_SRLV: ex_wd = b >> a[4:0];
            mie_pkg::FN_SRAV: ex_wd = $signed(b) >>> a[4:0];
            mie_pkg::FN_JR: begin
               ex_we = 1'b0;
               ex_kind = mie_pkg::RK_BRANCH;
               ex_npc = {a[31:2], 2'b00};
            end
            mie_pkg::FN_JALR: begin
               ex_wd = pc8;
               ex_kind = mie_pkg::RK_BRANCH;
               ex_npc = {a[31:2], 2'b00};
            end
            mie_pkg::FN_SYSCALL: begin
               ex_we = 1'b0;
               ex_kind = mie_pkg::RK_EXC;
               ex_exc = mie_pkg::EX_SYS;
            end
            mie_pkg::FN_BREAK: begin
               ex_we = 1'b0;
               ex_kind = mie_pkg::RK_EXC;
               ex_exc = mie_pkg::EX_BRK;
            end
            mie_pkg::FN_MFHI: ex_wd = hi_ff;
            mie_pkg::FN_MTHI: begin
               ex_we = 1'b0;
               ex_hwe = 1'b1;
            end
            mie_pkg::FN_MFLO: ex_wd = lo_ff;
            mie_pkg::FN_MTLO: begin
               ex_we = 1'b0;
               ex_lwe = 1'b1;
            end
            mie_pkg::FN_MULT, mie_pkg::FN_MULTU: begin
               ex_we = 1'b0;
               ex_mul = 1'b1;
               ex_sgn = (fn == mie_pkg::FN_MULT);
            end
            mie_pkg::FN_DIV, mie_pkg::FN_DIVU: begin
               ex_we = 1'b0;
               ex_sgn = (fn == mie_pkg::FN_DIV);
               if (b == 32'h0) begin
                  ex_hwe = 1'b1;
                  ex_lwe = 1'b1;
                  ex_ld = (ex_sgn && a[31]) ? 32'd1 : 32'hFFFFFFFF;
               end else begin
                  ex_div = 1'b1;
               end
            end
            mie_pkg::FN_ADD: begin
               ex_wd = sum;
               if (((a ^ sum) & (b ^ sum)) >> 31 != 32'h0) begin
                  ex_we = 1'b0;
                  ex_kind = mie_pkg::RK_EXC;
                  ex_exc = mie_pkg::EX_OVF;
               end
            end
            mie_pkg::FN_ADDU: ex_wd = sum;
            mie_pkg::FN_SUB: begin
               ex_wd = dif;
               if (((a ^ b) & (a ^ dif)) >> 31 != 32'h0) begin
                  ex_we = 1'b0;
                  ex_kind = mie_pkg::RK_EXC;
                  ex_exc = mie_pkg::EX_OVF;
               end
            end
            mie_pkg::FN_SUBU: ex_wd = dif;
            mie_pkg::FN_AND:  ex_wd = a & b;
            mie_pkg::FN_OR:   ex_wd = a | b;
            mie_pkg::FN_XOR:  ex_wd = a ^ b;
            mie_pkg::FN_NOR:  ex_wd = ~(a | b);
            mie_pkg::FN_SLT:  ex_wd = {31'h0, $signed(a) < $signed(b)};
            mie_pkg::FN_SLTU: ex_wd = {31'h0, a < b};
            default: begin
               ex_we = 1'b0;
               ex_kind = mie_pkg::RK_EXC;
               ex_exc = mie_pkg::EX_RI;
            end
         endcase
      end else if (op == mie_pkg::OP_REGIMM) begin
         if (rt == mie_pkg::RT_BLTZ || rt == mie_pkg::RT_BGEZ ||
             rt == mie_pkg::RT_BLTZAL || rt == mie_pkg::RT_BGEZAL) begin
            ex_we = rt[4];
            ex_wa = mie_pkg::LINK_REG;
            ex_wd = pc8;
            if (rt[0] != a[31]) begin
               ex_kind = mie_pkg::RK_BRANCH;
               ex_npc = br_tgt;
            end
         end else begin
            ex_kind = mie_pkg::RK_EXC;
            ex_exc = mie_pkg::EX_RI;
         end
      end else begin
         ex_wa = rt;
         ex_wd = t;
         case (op)
            mie_pkg::OP_J, mie_pkg::OP_JAL: begin
               ex_we = (op == mie_pkg::OP_JAL);
               ex_wa = mie_pkg::LINK_REG;
               ex_wd = pc8;
               ex_kind = mie_pkg::RK_BRANCH;
               ex_npc = {pc4[31:28], ins_ff[25:0], 2'b00};
            end
            mie_pkg::OP_BEQ, mie_pkg::OP_BNE, mie_pkg::OP_BLEZ, mie_pkg::OP_BGTZ: begin
               logic tk;
               case (op)
                  mie_pkg::OP_BEQ:  tk = (a == b);
                  mie_pkg::OP_BNE:  tk = (a != b);
                  mie_pkg::OP_BLEZ: tk = a[31] || (a == 32'h0);
                  default:          tk = !a[31] && (a != 32'h0);
               endcase
               if (tk) begin
                  ex_kind = mie_pkg::RK_BRANCH;
                  ex_npc = br_tgt;
               end
            end
            mie_pkg::OP_ADDI: begin
               if (((a ^ t) & (simm ^ t)) >> 31 != 32'h0) begin
                  ex_kind = mie_pkg::RK_EXC;
                  ex_exc = mie_pkg::EX_OVF;
               end else begin
                  ex_we = 1'b1;
               end
            end
            mie_pkg::OP_ADDIU: ex_we = 1'b1;
            mie_pkg::OP_SLTI: begin
               ex_we = 1'b1;
               ex_wd = {31'h0, $signed(a) < $signed(simm)};
            end
            mie_pkg::OP_SLTIU: begin
               ex_we = 1'b1;
               ex_wd = {31'h0, a < simm};
            end
            mie_pkg::OP_ANDI: begin
               ex_we = 1'b1;
               ex_wd = a & imm;
            end
            mie_pkg::OP_ORI: begin
               ex_we = 1'b1;
               ex_wd = a | imm;
            end
            mie_pkg::OP_XORI: begin
               ex_we = 1'b1;
               ex_wd = a ^ imm;
            end
            mie_pkg::OP_LUI: begin
               ex_we = 1'b1;
               ex_wd = {ins_ff[15:0], 16'h0000};
            end
            mie_pkg::OP_COP0, mie_pkg::OP_COP1, mie_pkg::OP_COP2, mie_pkg::OP_COP3,
            mie_pkg::OP_LWC0, mie_pkg::OP_LWC1, mie_pkg::OP_LWC2, mie_pkg::OP_LWC3,
            mie_pkg::OP_SWC0, mie_pkg::OP_SWC1, mie_pkg::OP_SWC2, mie_pkg::OP_SWC3: begin
               ex_kind = mie_pkg::RK_EXC;
               ex_exc = mie_pkg::EX_CPU;
               ex_cop = op[1:0];
            end
            mie_pkg::OP_LB, mie_pkg::OP_LH, mie_pkg::OP_LWL, mie_pkg::OP_LW,
            mie_pkg::OP_LBU, mie_pkg::OP_LHU, mie_pkg::OP_LWR: begin
               ex_addr = t;
               if (((op == mie_pkg::OP_LH || op == mie_pkg::OP_LHU) && t[0]) ||
                   (op == mie_pkg::OP_LW && t[1:0] != 2'b00)) begin
                  ex_kind = mie_pkg::RK_EXC;
                  ex_exc = mie_pkg::EX_ADEL;
               end else begin
                  ex_kind = mie_pkg::RK_LOAD;
                  ex_ldset = 1'b1;
                  case (op)
                     mie_pkg::OP_LB:  ex_ldt = mie_pkg::LT_LB;
                     mie_pkg::OP_LBU: ex_ldt = mie_pkg::LT_LBU;
                     mie_pkg::OP_LH:  ex_ldt = mie_pkg::LT_LH;
                     mie_pkg::OP_LHU: ex_ldt = mie_pkg::LT_LHU;
                     mie_pkg::OP_LW:  ex_ldt = mie_pkg::LT_LW;
                     mie_pkg::OP_LWL: ex_ldt = mie_pkg::LT_LWL;
                     default:         ex_ldt = mie_pkg::LT_LWR;
                  endcase
               end
            end
            mie_pkg::OP_SB: begin
               ex_kind = mie_pkg::RK_STORE;
               ex_addr = t;
               ex_sd = b << sh;
               ex_mask = 4'b0001 << t[1:0];
            end
            mie_pkg::OP_SH: begin
               ex_addr = t;
               if (t[0]) begin
                  ex_kind = mie_pkg::RK_EXC;
                  ex_exc = mie_pkg::EX_ADES;
               end else begin
                  ex_kind = mie_pkg::RK_STORE;
                  ex_sd = {16'h0000, b[15:0]} << sh;
                  ex_mask = 4'b0011 << t[1:0];
               end
            end
            mie_pkg::OP_SWL: begin
               ex_kind = mie_pkg::RK_STORE;
               ex_addr = t;
               ex_sd = b >> shc;
               ex_mask = 4'b1111 >> (2'd3 - t[1:0]);
            end
            mie_pkg::OP_SW: begin
               ex_addr = t;
               if (t[1:0] != 2'b00) begin
                  ex_kind = mie_pkg::RK_EXC;
                  ex_exc = mie_pkg::EX_ADES;
               end else begin
                  ex_kind = mie_pkg::RK_STORE;
                  ex_sd = b;
                  ex_mask = 4'b1111;
               end
            end
            mie_pkg::OP_SWR: begin
               ex_kind = mie_pkg::RK_STORE;
               ex_addr = t;
               ex_sd = b << sh;
               ex_mask = 4'b1111 << t[1:0];
            end
            default: begin
               ex_kind = mie_pkg::RK_EXC;
               ex_exc = mie_pkg::EX_RI;
            end
         endcase
      end
   end

   // shared step unit: add for multiply, trial subtract for divide
   always_comb begin
      au_sub = (state_ff == S_DIV);
      if (au_sub) begin
         au_x = {mh_ff, ml_ff[31]};
         au_y = {1'b0, mc_ff};
      end else begin
         au_x = {1'b0, mh_ff};
         au_y = ml_ff[0] ? {1'b0, mc_ff} : 33'h0;
      end
      au_sum = {1'b0, au_x} + {1'b0, au_sub ? ~au_y : au_y} + {33'h0, au_sub};
   end

   assign prod_neg = 64'h0 - {mh_ff, ml_ff};

   always_comb begin
      we = 1'b0;
      wa = ex_wa;
      wd = ex_wd;
      if (do_commit && ex_we && ex_wa != 5'd0) begin
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         rda_ff <= gpr_mem[rs];
         rdb_ff <= gpr_mem[rdb_addr];
      end
      if (we) begin
         gpr_mem[wa] <= wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vld_ff       <= '0;
         hi_ff        <= '0;
         lo_ff        <= '0;
         ldp_ff       <= 1'b0;
         ldd_ff       <= '0;
         ldt_ff       <= mie_pkg::LT_LB;
         ldo_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !do_commit) begin
            rsp_valid_ff <= 1'b0;
         end
         if (we) begin
            vld_ff[wa] <= 1'b1;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  kind_ff  <= req_kind;
                  ins_ff   <= req_instruction;
                  pc_ff    <= req_instr_address;
                  slot_ff  <= req_in_delay_slot;
                  lw_ff    <= req_load_word;
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_EXEC;
            S_EXEC: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rk_ff    <= ex_kind;
                  exc_ff   <= (ex_kind == mie_pkg::RK_EXC) ? ex_exc : mie_pkg::EX_ADEL;
                  addr_ff  <= ex_addr;
                  sd_ff    <= ex_sd;
                  mask_ff  <= ex_mask;
                  npc_ff   <= ex_npc;
                  cop_ff   <= ex_cop;
                  eslot_ff <= (ex_kind == mie_pkg::RK_EXC) ? slot_ff : 1'b0;
                  ldp_ff   <= ex_ldset;
                  if (ex_ldset) begin
                     ldd_ff <= rt;
                     ldt_ff <= ex_ldt;
                     ldo_ff <= t[1:0];
                  end
                  if (ex_hwe) hi_ff <= ex_hd;
                  if (ex_lwe) lo_ff <= ex_ld;
                  mh_ff    <= '0;
                  ml_ff    <= (ex_sgn && a[31]) ? 32'h0 - a : a;
                  mc_ff    <= (ex_sgn && b[31]) ? 32'h0 - b : b;
                  qneg_ff  <= ex_sgn && (a[31] ^ b[31]);
                  rneg_ff  <= ex_sgn && a[31];
                  ismul_ff <= ex_mul;
                  cnt_ff   <= '0;
                  if (ex_mul) state_ff <= S_MUL;
                  else if (ex_div) state_ff <= S_DIV;
                  else state_ff <= S_IDLE;
               end
            end
            S_MUL: begin
               mh_ff  <= au_sum[32:1];
               ml_ff  <= {au_sum[0], ml_ff[31:1]};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) state_ff <= S_FIX;
            end
            S_DIV: begin
               if (au_sum[33]) begin
                  mh_ff <= au_sum[31:0];
                  ml_ff <= {ml_ff[30:0], 1'b1};
               end else begin
                  mh_ff <= {mh_ff[30:0], ml_ff[31]};
                  ml_ff <= {ml_ff[30:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) state_ff <= S_FIX;
            end
            S_FIX: begin
               if (ismul_ff) begin
                  hi_ff <= qneg_ff ? prod_neg[63:32] : mh_ff;
                  lo_ff <= qneg_ff ? prod_neg[31:0] : ml_ff;
               end else begin
                  hi_ff <= rneg_ff ? 32'h0 - mh_ff : mh_ff;
                  lo_ff <= qneg_ff ? 32'h0 - ml_ff : ml_ff;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_zero_reg: assert property (@(posedge clock) disable iff (reset) !vld_ff[0])
      else $error("register zero marked written");

   a_load_req: assert property (@(posedge clock) disable iff (reset)
      $rose(ldp_ff) |-> rsp_valid_ff && rk_ff == mie_pkg::RK_LOAD)
      else $error("load pending without load request");

   a_exc_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rk_ff == mie_pkg::RK_EXC |-> mask_ff == 4'h0)
      else $error("exception carries store lanes");

endmodule
